// ----- rtl/core/hdmtc_pkg.sv -----
// Shared types and constants of the hashed direct-mapped tag cache.
package hdmtc_pkg;

    // hash constants
    localparam logic [63:0] HASH_MUL   = 64'hc6a4a7935bd1e995;
    localparam logic [63:0] HASH_SEED  = 64'd4193360111;
    localparam int          HASH_SHIFT = 47;
    localparam logic [63:0] HASH_INIT  = HASH_SEED ^ {HASH_MUL[60:0], 3'b000};

    // widths
    localparam int CFG_W = 9;
    localparam int IDX_W = 9;

    // command codes
    localparam logic [1:0] CMD_LOOKUP = 2'd0;
    localparam logic [1:0] CMD_MARK   = 2'd1;
    localparam logic [1:0] CMD_QUERY  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    // classified item passed from front to back
    typedef struct packed {
        logic [1:0]       cmd;
        logic [63:0]      key;
        logic [IDX_W-1:0] idx;
        logic             in_range;
    } entry_t;

endpackage

// ----- rtl/core/hashed_direct_mapped_tag_cache_top.sv -----
// Top level of the hashed direct-mapped tag cache.
//
//  channel  direction  ports
//  s_       in         s_valid s_ready s_command s_key s_slot
//  m_       out        m_valid m_ready m_slot_index m_hit m_evicted
//                      m_evicted_key m_valid_bit m_error
//  cfg_     in         cfg_valid cfg_ready cfg_data (entries_in_use)
//
// A lookup passes through four 64-bit multiplies on one shared 32x32
// multiplier, a bit-serial restoring remainder, a queue hop and the store
// read-modify-write. The front takes no new beat on s_ until it has pushed
// the current one into the queue; other commands skip the hash and the
// remainder. After reset a clearing pass zeroes min(ENTRIES, 512) rows of
// the store; no beat is accepted on s_ meanwhile. A stalled m_ beat holds
// in the result register while the front keeps hashing the next beat.
module hashed_direct_mapped_tag_cache_top #(
    parameter int ENTRIES = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_key,
    input  logic [7:0]  s_slot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_slot_index,
    output logic        m_hit,
    output logic        m_evicted,
    output logic [63:0] m_evicted_key,
    output logic        m_valid_bit,
    output logic        m_error
);

    logic [hdmtc_pkg::CFG_W-1:0] entries_reg;
    logic              clearing;
    logic              push_valid, push_ready;
    logic              pop_valid, pop_ready;
    hdmtc_pkg::entry_t push_entry, pop_entry;

    assign cfg_ready = 1'b1;

    // hold slot count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            entries_reg <= 9'd256;
        end else if (cfg_valid && cfg_ready) begin
            entries_reg <= cfg_data;
        end
    end

    hdmtc_front #(.ENTRIES(ENTRIES)) u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_command      (s_command),
        .s_key          (s_key),
        .s_slot         (s_slot),
        .hold           (clearing),
        .entries_in_use (entries_reg),
        .push_valid     (push_valid),
        .push_ready     (push_ready),
        .push_entry     (push_entry)
    );

    hdmtc_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_entry (push_entry),
        .rd_valid (pop_valid),
        .rd_ready (pop_ready),
        .rd_entry (pop_entry)
    );

    hdmtc_back #(.ENTRIES(ENTRIES)) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_valid       (pop_valid),
        .q_ready       (pop_ready),
        .q_entry       (pop_entry),
        .clearing      (clearing),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_slot_index  (m_slot_index),
        .m_hit         (m_hit),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key),
        .m_valid_bit   (m_valid_bit),
        .m_error       (m_error)
    );

endmodule

// ----- rtl/core/hdmtc_front.sv -----
// Front end: accepts items, hashes lookup keys and reduces them to a slot.
module hdmtc_front #(
    parameter int ENTRIES = 256
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  logic [1:0]                 s_command,
    input  logic [63:0]                s_key,
    input  logic [7:0]                 s_slot,
    input  logic                       hold,
    input  logic [hdmtc_pkg::CFG_W-1:0] entries_in_use,
    output logic                       push_valid,
    input  logic                       push_ready,
    output hdmtc_pkg::entry_t          push_entry
);

    localparam int          CAP   = (ENTRIES < 511) ? ENTRIES : 511;
    localparam logic [8:0]  CAP9  = 9'(CAP);
    localparam logic [16:0] ENT17 = 17'(ENTRIES);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_MOD  = 2'd2;
    localparam logic [1:0] ST_PUSH = 2'd3;

    logic [1:0]  st_reg, st_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  mstep_reg, mstep_next;
    logic [5:0]  bit_reg, bit_next;
    logic [63:0] a_reg, a_next;
    logic [63:0] sum_reg, sum_next;
    logic [63:0] prod_reg, prod_next;
    logic [8:0]  rem_reg, rem_next;
    logic [8:0]  n_reg, n_next;
    hdmtc_pkg::entry_t ent_reg, ent_next;

    logic [31:0] op_a, op_b;
    logic [63:0] sum_fin;
    logic [63:0] post;
    logic [9:0]  rem_sh;
    logic [8:0]  n_eff;

    assign s_ready    = (st_reg == ST_IDLE) && !hold;
    assign push_valid = (st_reg == ST_PUSH);
    assign push_entry = ent_reg;

    // clamp slot count
    always_comb begin
        if (entries_in_use == 9'd0) begin
            n_eff = 9'd1;
        end else if (entries_in_use > CAP9) begin
            n_eff = CAP9;
        end else begin
            n_eff = entries_in_use;
        end
    end

    // shared 32x32 multiplier operands per phase
    always_comb begin
        case (phase_reg)
            2'd0: begin
                op_a = a_reg[31:0];
                op_b = hdmtc_pkg::HASH_MUL[31:0];
            end
            2'd1: begin
                op_a = a_reg[63:32];
                op_b = hdmtc_pkg::HASH_MUL[31:0];
            end
            default: begin
                op_a = a_reg[31:0];
                op_b = hdmtc_pkg::HASH_MUL[63:32];
            end
        endcase
    end

    assign sum_fin = sum_reg + {prod_reg[31:0], 32'd0};
    assign post = (mstep_reg == 2'd1) ? (hdmtc_pkg::HASH_INIT ^ sum_fin)
                                      : (sum_fin ^ (sum_fin >> hdmtc_pkg::HASH_SHIFT));
    assign rem_sh = {rem_reg, a_reg[63]};

    // sequence hash and modulo
    always_comb begin
        st_next    = st_reg;
        phase_next = phase_reg;
        mstep_next = mstep_reg;
        bit_next   = bit_reg;
        a_next     = a_reg;
        sum_next   = sum_reg;
        prod_next  = prod_reg;
        rem_next   = rem_reg;
        n_next     = n_reg;
        ent_next   = ent_reg;
        case (st_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    ent_next.cmd      = s_command;
                    ent_next.key      = s_key;
                    ent_next.idx      = {1'b0, s_slot};
                    ent_next.in_range = ({9'd0, s_slot} < ENT17);
                    a_next     = s_key;
                    phase_next = 2'd0;
                    mstep_next = 2'd0;
                    n_next     = n_eff;
                    if (s_command == hdmtc_pkg::CMD_LOOKUP) begin
                        ent_next.in_range = 1'b1;
                        st_next = ST_MUL;
                    end else begin
                        st_next = ST_PUSH;
                    end
                end
            end
            ST_MUL: begin
                prod_next  = 64'(op_a * op_b);
                phase_next = phase_reg + 2'd1;
                case (phase_reg)
                    2'd1: sum_next = prod_reg;
                    2'd2: sum_next = sum_fin;
                    2'd3: begin
                        a_next     = post;
                        mstep_next = mstep_reg + 2'd1;
                        if (mstep_reg == 2'd3) begin
                            rem_next = 9'd0;
                            bit_next = 6'd0;
                            st_next  = ST_MOD;
                        end
                    end
                    default: ;
                endcase
            end
            ST_MOD: begin
                if (rem_sh >= {1'b0, n_reg}) begin
                    rem_next = 9'(rem_sh - {1'b0, n_reg});
                end else begin
                    rem_next = rem_sh[8:0];
                end
                a_next   = {a_reg[62:0], 1'b0};
                bit_next = bit_reg + 6'd1;
                if (bit_reg == 6'd63) begin
                    ent_next.idx = rem_next;
                    st_next = ST_PUSH;
                end
            end
            default: begin
                if (push_ready) begin
                    st_next = ST_IDLE;
                end
            end
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg    <= ST_IDLE;
            phase_reg <= 2'd0;
            mstep_reg <= 2'd0;
            bit_reg   <= 6'd0;
        end else begin
            st_reg    <= st_next;
            phase_reg <= phase_next;
            mstep_reg <= mstep_next;
            bit_reg   <= bit_next;
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        a_reg    <= a_next;
        sum_reg  <= sum_next;
        prod_reg <= prod_next;
        rem_reg  <= rem_next;
        n_reg    <= n_next;
        ent_reg  <= ent_next;
    end

endmodule

// ----- rtl/core/hdmtc_queue.sv -----
// Two-entry queue between front and back.
module hdmtc_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_valid,
    output logic              wr_ready,
    input  hdmtc_pkg::entry_t wr_entry,
    output logic              rd_valid,
    input  logic              rd_ready,
    output hdmtc_pkg::entry_t rd_entry
);

    hdmtc_pkg::entry_t slot_reg [2];
    logic       wptr_reg, wptr_next;
    logic       rptr_reg, rptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       do_wr, do_rd;

    assign wr_ready = (cnt_reg != 2'd2);
    assign rd_valid = (cnt_reg != 2'd0);
    assign rd_entry = slot_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_valid && rd_ready;

    // advance pointers
    always_comb begin
        wptr_next = do_wr ? !wptr_reg : wptr_reg;
        rptr_next = do_rd ? !rptr_reg : rptr_reg;
        cnt_next  = cnt_reg + {1'b0, do_wr} - {1'b0, do_rd};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end else begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wptr_reg] <= wr_entry;
        end
    end

endmodule

// ----- rtl/core/hdmtc_back.sv -----
// Back end: tag and valid store, read-modify-write and result register.
module hdmtc_back #(
    parameter int ENTRIES = 256
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    output logic              q_ready,
    input  hdmtc_pkg::entry_t q_entry,
    output logic              clearing,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_slot_index,
    output logic              m_hit,
    output logic              m_evicted,
    output logic [63:0]       m_evicted_key,
    output logic              m_valid_bit,
    output logic              m_error
);

    localparam int DEPTH = (ENTRIES < 512) ? ENTRIES : 512;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    localparam logic [1:0] ST_CLEAR = 2'd0;
    localparam logic [1:0] ST_IDLE  = 2'd1;
    localparam logic [1:0] ST_EXEC  = 2'd2;

    // row: valid bit over tag
    logic [64:0] mem [DEPTH];
    logic [64:0] rdata_reg;

    logic [1:0]    st_reg, st_next;
    logic [AW-1:0] clr_reg, clr_next;
    hdmtc_pkg::entry_t cur_reg;
    logic          ov_reg, ov_next;
    logic [7:0]    o_slot_reg, o_slot_next;
    logic          o_hit_reg, o_hit_next;
    logic          o_ev_reg, o_ev_next;
    logic [63:0]   o_evk_reg, o_evk_next;
    logic          o_vb_reg, o_vb_next;
    logic          o_err_reg, o_err_next;

    logic          we;
    logic [AW-1:0] waddr;
    logic [64:0]   wdata;
    logic          out_free;
    logic          row_v;
    logic [63:0]   row_tag;

    assign clearing = (st_reg == ST_CLEAR);
    assign q_ready  = (st_reg == ST_IDLE);
    assign out_free = !ov_reg || m_ready;
    assign row_v    = rdata_reg[64];
    assign row_tag  = rdata_reg[63:0];

    assign m_valid       = ov_reg;
    assign m_slot_index  = o_slot_reg;
    assign m_hit         = o_hit_reg;
    assign m_evicted     = o_ev_reg;
    assign m_evicted_key = o_evk_reg;
    assign m_valid_bit   = o_vb_reg;
    assign m_error       = o_err_reg;

    // execute command against the read row
    always_comb begin
        st_next     = st_reg;
        clr_next    = clr_reg;
        ov_next     = ov_reg && !m_ready;
        o_slot_next = o_slot_reg;
        o_hit_next  = o_hit_reg;
        o_ev_next   = o_ev_reg;
        o_evk_next  = o_evk_reg;
        o_vb_next   = o_vb_reg;
        o_err_next  = o_err_reg;
        we          = 1'b0;
        waddr       = cur_reg.idx[AW-1:0];
        wdata       = 65'd0;
        case (st_reg)
            ST_CLEAR: begin
                we       = 1'b1;
                waddr    = clr_reg;
                clr_next = clr_reg + 1'b1;
                if (clr_reg == LAST) begin
                    st_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (q_valid) begin
                    st_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (out_free) begin
                    ov_next     = 1'b1;
                    o_slot_next = cur_reg.idx[7:0];
                    o_hit_next  = 1'b0;
                    o_ev_next   = 1'b0;
                    o_evk_next  = 64'd0;
                    o_vb_next   = 1'b0;
                    o_err_next  = 1'b0;
                    st_next     = ST_IDLE;
                    case (cur_reg.cmd)
                        hdmtc_pkg::CMD_LOOKUP: begin
                            if (row_v && (row_tag == cur_reg.key)) begin
                                o_hit_next = 1'b1;
                                o_vb_next  = 1'b1;
                            end else begin
                                we    = 1'b1;
                                wdata = {1'b0, cur_reg.key};
                                if (row_v) begin
                                    o_ev_next  = 1'b1;
                                    o_evk_next = row_tag;
                                end
                            end
                        end
                        hdmtc_pkg::CMD_MARK: begin
                            if (cur_reg.in_range) begin
                                we         = 1'b1;
                                wdata      = {1'b1, row_tag};
                                o_err_next = row_v;
                                o_vb_next  = 1'b1;
                            end
                        end
                        hdmtc_pkg::CMD_QUERY: begin
                            o_vb_next = cur_reg.in_range && row_v;
                        end
                        default: ;
                    endcase
                end
            end
            default: st_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg  <= ST_CLEAR;
            clr_reg <= '0;
            ov_reg  <= 1'b0;
        end else begin
            st_reg  <= st_next;
            clr_reg <= clr_next;
            ov_reg  <= ov_next;
        end
    end

    // result payload and popped item
    always_ff @(posedge aclk) begin
        o_slot_reg <= o_slot_next;
        o_hit_reg  <= o_hit_next;
        o_ev_reg   <= o_ev_next;
        o_evk_reg  <= o_evk_next;
        o_vb_reg   <= o_vb_next;
        o_err_reg  <= o_err_next;
        if (q_valid && q_ready) begin
            cur_reg <= q_entry;
        end
    end

    // store: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (q_valid && q_ready) begin
            rdata_reg <= mem[q_entry.idx[AW-1:0]];
        end
    end

endmodule

// ----- rtl/core/hdmtc_checker.sv -----
// Port-level checker for the tag cache and its bind.
module hdmtc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [7:0]  m_slot_index,
    input logic        m_hit,
    input logic        m_evicted,
    input logic [63:0] m_evicted_key,
    input logic        m_valid_bit,
    input logic        m_error
);

    // a hit never evicts
    a_hit_no_evict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_hit && m_evicted))
        else $error("hit and eviction together");

    // evicted key is zero without eviction
    a_evk_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_evicted) |-> (m_evicted_key == 64'd0))
        else $error("stray evicted key");

    // mark-valid error leaves the slot valid
    a_err_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_error) |-> (m_valid_bit && !m_hit && !m_evicted))
        else $error("error without valid bit");

    // stalled beat holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_slot_index)
                                   && $stable(m_evicted_key)))
        else $error("stalled beat changed");

endmodule

bind hashed_direct_mapped_tag_cache_top hdmtc_checker u_hdmtc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_slot_index  (m_slot_index),
    .m_hit         (m_hit),
    .m_evicted     (m_evicted),
    .m_evicted_key (m_evicted_key),
    .m_valid_bit   (m_valid_bit),
    .m_error       (m_error)
);

// ----- bench/hashed_direct_mapped_tag_cache_checker.sv -----
// Result checker for the hashed direct-mapped tag cache: predicts and compares each beat.
`timescale 1ns / 1ps
module hashed_direct_mapped_tag_cache_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [8:0]  cfg_data,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [63:0] s_key,
    input  logic [7:0]  s_slot,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [7:0]  m_slot_index,
    input  logic        m_hit,
    input  logic        m_evicted,
    input  logic [63:0] m_evicted_key,
    input  logic        m_valid_bit,
    input  logic        m_error,
    output int          fail_count,
    output int          pending
);

    typedef struct packed {
        logic [7:0]  slot_index;
        logic        hit;
        logic        evicted;
        logic [63:0] evicted_key;
        logic        valid_bit;
        logic        error;
    } outcome_t;

    localparam int NSLOTS = 256;

    logic [8:0]  slots_used;
    logic        tag_valid [NSLOTS];
    logic [63:0] tag_store [NSLOTS];
    outcome_t    expected_q [$];

    // MurmurHash64A of one 8-byte key
    function automatic logic [63:0] murmur_mix(input logic [63:0] k);
        logic [63:0] h;
        h = hdmtc_pkg::HASH_SEED ^ (64'd8 * hdmtc_pkg::HASH_MUL);
        k = k * hdmtc_pkg::HASH_MUL;
        k = k ^ (k >> hdmtc_pkg::HASH_SHIFT);
        k = k * hdmtc_pkg::HASH_MUL;
        h = h ^ k;
        h = h * hdmtc_pkg::HASH_MUL;
        h = h ^ (h >> hdmtc_pkg::HASH_SHIFT);
        h = h * hdmtc_pkg::HASH_MUL;
        h = h ^ (h >> hdmtc_pkg::HASH_SHIFT);
        return h;
    endfunction

    function automatic outcome_t apply_command(input logic [1:0] cmd, input logic [63:0] key,
                                               input logic [7:0] slot);
        outcome_t    o;
        logic [63:0] n;
        logic [63:0] i;
        o = '0;
        o.slot_index = slot;
        if (slots_used == 9'd0) n = 64'd1;
        else if (slots_used > 9'(NSLOTS)) n = 64'(NSLOTS);
        else n = {55'd0, slots_used};
        if (cmd == hdmtc_pkg::CMD_LOOKUP) begin
            i = murmur_mix(key) % n;
            o.slot_index = i[7:0];
            if (!tag_valid[i]) begin
                tag_store[i] = key;
            end else if (tag_store[i] == key) begin
                o.hit = 1'b1;
                o.valid_bit = 1'b1;
            end else begin
                o.evicted = 1'b1;
                o.evicted_key = tag_store[i];
                tag_valid[i] = 1'b0;
                tag_store[i] = key;
            end
        end else if (cmd == hdmtc_pkg::CMD_MARK) begin
            o.error = tag_valid[slot];
            tag_valid[slot] = 1'b1;
            o.valid_bit = 1'b1;
        end else if (cmd == hdmtc_pkg::CMD_QUERY) begin
            o.valid_bit = tag_valid[slot];
        end
        return o;
    endfunction

    // predict on accepted input beats, compare on accepted result beats
    always @(posedge aclk) begin
        outcome_t got;
        outcome_t want;
        if (!aresetn) begin
            slots_used <= 9'd256;
            for (int j = 0; j < NSLOTS; j++) begin
                tag_valid[j] = 1'b0;
                tag_store[j] = '0;
            end
            expected_q.delete();
            fail_count <= 0;
            pending <= 0;
        end else begin
            if (cfg_valid && cfg_ready) slots_used <= cfg_data;
            if (s_valid && s_ready) expected_q.push_back(apply_command(s_command, s_key, s_slot));
            if (m_valid && m_ready) begin
                got = {m_slot_index, m_hit, m_evicted, m_evicted_key, m_valid_bit, m_error};
                if (expected_q.size() == 0) begin
                    $display("%0t: result beat with none expected: %h", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = expected_q.pop_front();
                    if (got != want) begin
                        $display("%0t: mismatch expected slot %0d hit %b ev %b key %h vb %b err %b",
                                 $time, want.slot_index, want.hit, want.evicted,
                                 want.evicted_key, want.valid_bit, want.error);
                        $display("%0t:          actual   slot %0d hit %b ev %b key %h vb %b err %b",
                                 $time, got.slot_index, got.hit, got.evicted,
                                 got.evicted_key, got.valid_bit, got.error);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            pending <= expected_q.size();
        end
    end
endmodule

// ----- bench/hashed_direct_mapped_tag_cache_top_tb.sv -----
// Stimulus and verdict for the hashed direct-mapped tag cache.
`timescale 1ns / 1ps
module hashed_direct_mapped_tag_cache_top_tb;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [8:0]  cfg_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_command = hdmtc_pkg::CMD_QUERY;
    logic [63:0] s_key = '0;
    logic [7:0]  s_slot = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [7:0]  m_slot_index;
    logic        m_hit;
    logic        m_evicted;
    logic [63:0] m_evicted_key;
    logic        m_valid_bit;
    logic        m_error;
    int          fail_count;
    int          pending;
    bit          drain_mode = 1'b0;

    // keys already stored as tags, reused to make hits
    logic [63:0] seen_keys [$];
    // slots that some lookup has given a tag, the only ones safe to mark
    bit          tag_written [256];

    always #2 aclk = ~aclk;

    hashed_direct_mapped_tag_cache_top uut (.*);

    hashed_direct_mapped_tag_cache_checker chk (.*);

    // idle cycles before a beat; valid always drops between beats
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) return 1;
        if (r < 90) return $urandom_range(1, 4);
        return $urandom_range(10, 120);
    endfunction

    // receiver stalls at random, with ready held high while draining
    always @(posedge aclk) begin
        if (!aresetn) m_ready <= 1'b0;
        else if (drain_mode) m_ready <= 1'b1;
        else m_ready <= ($urandom_range(0, 99) < 70);
    end

    task automatic send_beat(input logic [1:0] cmd, input logic [63:0] key, input logic [7:0] slot);
        int g;
        g = gap_length();
        repeat (g) @(posedge aclk);
        s_valid   <= 1'b1;
        s_command <= cmd;
        s_key     <= key;
        s_slot    <= slot;
        do @(posedge aclk); while (!s_ready);
        s_valid <= 1'b0;
        if (cmd == hdmtc_pkg::CMD_LOOKUP) seen_keys.push_back(key);
    endtask

    task automatic wait_idle();
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic write_slots(input logic [8:0] n);
        cfg_valid <= 1'b1;
        cfg_data  <= n;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        // tag-written knowledge is per physical slot, so it stays
    endtask

    // lookup that records which slot it tagged, by the checker's hash
    task automatic lookup(input logic [63:0] key);
        send_beat(hdmtc_pkg::CMD_LOOKUP, key, 8'($urandom()));
        wait_tag(key);
    endtask

    task automatic wait_tag(input logic [63:0] key);
        // mark the slot the lookup chose as holding a tag
        tag_written[chk.murmur_mix(key) % eff_slots()] = 1'b1;
    endtask

    function automatic int eff_slots();
        return (cfg_data == 9'd0) ? 1 : (cfg_data > 9'd256 ? 256 : int'(cfg_data));
    endfunction

    task automatic mark(input logic [7:0] slot);
        if (tag_written[slot]) send_beat(hdmtc_pkg::CMD_MARK, 64'd0, slot);
        else send_beat(hdmtc_pkg::CMD_QUERY, 64'd0, slot);
    endtask

    task automatic random_beat();
        int r;
        logic [63:0] k;
        logic [7:0]  s;
        r = $urandom_range(0, 99);
        s = 8'($urandom_range(0, (eff_slots() > 1) ? eff_slots() - 1 : 0));
        if (r < 45) begin
            if (seen_keys.size() > 0 && $urandom_range(0, 1))
                k = seen_keys[$urandom_range(0, seen_keys.size() - 1)];
            else
                k = {$urandom(), $urandom()};
            lookup(k);
        end else if (r < 75) begin
            mark(s);
        end else if (r < 95) begin
            send_beat(hdmtc_pkg::CMD_QUERY, {$urandom(), $urandom()}, 8'($urandom()));
        end else begin
            send_beat(hdmtc_pkg::CMD_UNUSED, {$urandom(), $urandom()}, 8'($urandom()));
        end
    endtask

    initial begin
        logic [8:0] settings [5];
        settings = '{9'd256, 9'd1, 9'd0, 9'd511, 9'd7};
        cfg_data = 9'd256;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: extremes and every command
        write_slots(9'd256);
        lookup(64'd0);
        lookup(64'd0);
        lookup('1);
        lookup(64'h8000_0000_0000_0001);
        lookup(64'h5555_aaaa_5555_aaaa);
        for (int j = 0; j < 256; j++) begin
            if (tag_written[j]) begin
                mark(8'(j));
                mark(8'(j));
                send_beat(hdmtc_pkg::CMD_QUERY, '1, 8'(j));
                break;
            end
        end
        send_beat(hdmtc_pkg::CMD_QUERY, 64'd0, 8'd255);
        send_beat(hdmtc_pkg::CMD_QUERY, 64'd0, 8'd0);
        send_beat(hdmtc_pkg::CMD_UNUSED, '1, 8'hff);
        send_beat(hdmtc_pkg::CMD_UNUSED, 64'd0, 8'h00);
        for (int j = 0; j < 256; j++) if (tag_written[j]) mark(8'(j));
        lookup('1);
        lookup(64'h0123_4567_89ab_cdef);

        // hold off until every result is back
        wait_idle();

        // random phases over several slot counts
        foreach (settings[p]) begin
            write_slots(settings[p]);
            for (int n = 0; n < 400; n++) begin
                if (eff_slots() > 1 || $urandom_range(0, 3) == 0) random_beat();
                else if ($urandom_range(0, 1)) lookup({$urandom(), $urandom()});
                else mark(8'd0);
            end
            wait_idle();
        end

        drain_mode = 1'b1;
        wait_idle();
        if (fail_count == 0)
            $display("hashed_direct_mapped_tag_cache_top_tb: done, clean");
        else
            $display("hashed_direct_mapped_tag_cache_top_tb: done, errors");
        $finish;
    end

    // give up well past the slowest correct run
    initial begin
        #40ms;
        $display("hashed_direct_mapped_tag_cache_top_tb: done, errors");
        $finish;
    end
endmodule

// ----- sim.f -----
rtl/core/hdmtc_pkg.sv
rtl/core/hdmtc_front.sv
rtl/core/hdmtc_queue.sv
rtl/core/hdmtc_back.sv
rtl/core/hashed_direct_mapped_tag_cache_top.sv
rtl/core/hdmtc_checker.sv
bench/hashed_direct_mapped_tag_cache_checker.sv
bench/hashed_direct_mapped_tag_cache_top_tb.sv
